@@ rtl/fsc_shell_weight_filter_macros.svh @@
// assertion macros for the shell weight filter rtl
`ifndef FSC_SHELL_WEIGHT_FILTER_MACROS_SVH
`define FSC_SHELL_WEIGHT_FILTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define FSW_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FSW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fsw_pkg.sv @@
// shared types and constants of the shell weight filter
`default_nettype none
package fsw_pkg;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned CRD_W   = 8;
  localparam int unsigned SQ_W    = 16;
  localparam int unsigned WGT_W   = 17;
  localparam int unsigned OUTW_W  = 16;
  localparam int unsigned VOL_W   = 9;
  localparam int unsigned CFGI_W  = 2;
  localparam int unsigned RT_STEPS   = 10;
  localparam int unsigned DIV_STEPS  = 33;
  localparam int unsigned ROOT_STEPS = 17;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_VOXEL = 1'b1;

  localparam logic MODE_FINAL  = 1'b0;
  localparam logic MODE_BINARY = 1'b1;

  localparam logic [CFGI_W-1:0] CFG_FILTER_MODE   = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_VOLUME_SIZE   = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_FSC_THRESHOLD = 2'd2;

  localparam logic [VOL_W-1:0]        VOLUME_SIZE_RST = 9'd256;
  localparam logic signed [VAL_W-1:0] THRESHOLD_RST   = 16'sd14090;
  localparam logic [WGT_W-1:0]        WEIGHT_ONE      = 17'd32768;

  typedef struct packed {
    logic                    action;
    logic [IDX_W-1:0]        shell_index;
    logic signed [VAL_W-1:0] shell_value;
    logic [SQ_W-1:0]         sq_x;
    logic [SQ_W-1:0]         sq_y;
    logic [SQ_W-1:0]         sq_z;
  } q_item_t;

  typedef struct packed {
    logic                    start;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } wu_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [WGT_W-1:0] weight;
  } wu_wr_t;

  typedef enum logic [1:0] {
    WU_IDLE,
    WU_DIV,
    WU_ROOT,
    WU_DONE
  } wu_state_t;
endpackage
`default_nettype wire

@@ rtl/fsw_front.sv @@
// front stage: accepts transactions and squares the centre offsets
`default_nettype none
module fsw_front #(
  parameter int unsigned COEF_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_action,
  input  wire logic [fsw_pkg::IDX_W-1:0]           in_shell_index,
  input  wire logic signed [fsw_pkg::VAL_W-1:0]    in_shell_value,
  input  wire logic [fsw_pkg::CRD_W-1:0]           in_coord_x,
  input  wire logic [fsw_pkg::CRD_W-1:0]           in_coord_y,
  input  wire logic [fsw_pkg::CRD_W-1:0]           in_coord_z,
  input  wire logic signed [COEF_BITS-1:0]         in_coef_re,
  input  wire logic signed [COEF_BITS-1:0]         in_coef_im,
  input  wire logic [fsw_pkg::VOL_W-1:0]           volume_size,
  output logic                                     f_valid,
  input  wire logic                                f_ready,
  output fsw_pkg::q_item_t                         f_item,
  output logic [COEF_BITS-1:0]                     f_re,
  output logic [COEF_BITS-1:0]                     f_im
);
  logic                   f_valid_r;
  fsw_pkg::q_item_t       item_r;
  fsw_pkg::q_item_t       item_nxt;
  logic [COEF_BITS-1:0]   re_r;
  logic [COEF_BITS-1:0]   im_r;
  logic [8:0]             half;
  logic signed [8:0]      dx, dy, dz;
  logic signed [17:0]     px, py, pz;
  logic                   accept;

  assign in_ready = !f_valid_r || f_ready;
  assign accept   = in_valid && in_ready;
  assign half     = {1'b0, volume_size[8:1]};

  // offsets from the centre, squared
  always_comb begin
    dx = $signed({1'b0, in_coord_x}) - $signed(half);
    dy = $signed({1'b0, in_coord_y}) - $signed(half);
    dz = $signed({1'b0, in_coord_z}) - $signed(half);
    px = dx * dx;
    py = dy * dy;
    pz = dz * dz;
    item_nxt.action      = in_action;
    item_nxt.shell_index = in_shell_index;
    item_nxt.shell_value = in_shell_value;
    item_nxt.sq_x        = px[fsw_pkg::SQ_W-1:0];
    item_nxt.sq_y        = py[fsw_pkg::SQ_W-1:0];
    item_nxt.sq_z        = pz[fsw_pkg::SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (accept) begin
      f_valid_r <= 1'b1;
    end else if (f_ready) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
      re_r   <= in_coef_re;
      im_r   <= in_coef_im;
    end
  end

  assign f_valid = f_valid_r;
  assign f_item  = item_r;
  assign f_re    = re_r;
  assign f_im    = im_r;
endmodule
`default_nettype wire

@@ rtl/fsw_queue.sv @@
// small fifo between the front and back parts
`default_nettype none
module fsw_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output logic [DATA_W-1:0]      pop_data
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign push_ready = cnt_r != CNT_W'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

@@ rtl/fsw_wunit.sv @@
// shell weight unit: round(32768*sqrt(2v/(v+32768))) by serial divide and root
`default_nettype none
module fsw_wunit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  fsw_pkg::wu_req_t req,
  output logic            busy,
  output fsw_pkg::wu_wr_t  wr
);
  fsw_pkg::wu_state_t state_r, state_nxt;
  logic [5:0]          cnt_r;
  logic [15:0]         den_r;
  logic [16:0]         rem_r;
  logic [32:0]         q_r;
  logic [33:0]         x_r, res_r, one_r;
  logic [fsw_pkg::IDX_W-1:0] idx_r;
  logic [14:0]         vpos;
  logic [16:0]         rem_sh, rem_nxt;
  logic                div_ge;
  logic [32:0]         q_nxt;
  logic [33:0]         root_sum;
  logic                root_ge;
  logic [33:0]         res_inc;

  // non-positive values weigh zero: they run with a zero numerator
  assign vpos = (req.value > 0) ? req.value[14:0] : 15'd0;

  always_comb begin
    rem_sh   = {rem_r[15:0], 1'b0};
    div_ge   = rem_sh >= {1'b0, den_r};
    rem_nxt  = div_ge ? rem_sh - {1'b0, den_r} : rem_sh;
    q_nxt    = {q_r[31:0], div_ge};
    root_sum = res_r + one_r;
    root_ge  = x_r >= root_sum;
    res_inc  = res_r + 34'd1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fsw_pkg::WU_IDLE: if (req.start) state_nxt = fsw_pkg::WU_DIV;
      fsw_pkg::WU_DIV:  if (cnt_r == 6'(fsw_pkg::DIV_STEPS - 1)) state_nxt = fsw_pkg::WU_ROOT;
      fsw_pkg::WU_ROOT: if (cnt_r == 6'(fsw_pkg::ROOT_STEPS - 1)) state_nxt = fsw_pkg::WU_DONE;
      fsw_pkg::WU_DONE: state_nxt = fsw_pkg::WU_IDLE;
      default:          state_nxt = fsw_pkg::WU_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    wr.we     = 1'b0;
    wr.idx    = idx_r;
    wr.weight = res_inc[17:1];
    case (state_r)
      fsw_pkg::WU_IDLE: busy  = 1'b0;
      fsw_pkg::WU_DONE: wr.we = 1'b1;
      default:          busy  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsw_pkg::WU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      fsw_pkg::WU_IDLE: begin
        idx_r <= req.idx;
        den_r <= {1'b1, vpos};
        rem_r <= {2'b00, vpos};
        q_r   <= '0;
        cnt_r <= '0;
      end
      fsw_pkg::WU_DIV: begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        if (cnt_r == 6'(fsw_pkg::DIV_STEPS - 1)) begin
          x_r   <= {1'b0, q_nxt};
          res_r <= '0;
          one_r <= 34'd1 << 32;
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_r + 6'd1;
        end
      end
      fsw_pkg::WU_ROOT: begin
        if (root_ge) begin
          x_r   <= x_r - root_sum;
          res_r <= (res_r >> 1) + one_r;
        end else begin
          res_r <= res_r >> 1;
        end
        one_r <= one_r >> 2;
        cnt_r <= cnt_r + 6'd1;
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/fsw_back.sv @@
// back part: radius root pipeline, shell weight store and coefficient scaling
`default_nettype none
`include "fsc_shell_weight_filter_macros.svh"
module fsw_back #(
  parameter int unsigned COEF_BITS   = 32,
  parameter int unsigned SHELL_COUNT = 128
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_valid,
  output logic                                  q_pop,
  input  fsw_pkg::q_item_t                      q_item,
  input  wire logic [COEF_BITS-1:0]             q_re,
  input  wire logic [COEF_BITS-1:0]             q_im,
  input  wire logic                             filter_mode,
  input  wire logic [fsw_pkg::VOL_W-1:0]        volume_size,
  input  wire logic signed [fsw_pkg::VAL_W-1:0] fsc_threshold,
  input  wire logic                             wu_busy,
  output fsw_pkg::wu_req_t                      wu_req,
  input  fsw_pkg::wu_wr_t                       wu_wr,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [COEF_BITS-1:0]           out_re,
  output logic signed [COEF_BITS-1:0]           out_im,
  output logic [fsw_pkg::OUTW_W-1:0]            out_weight
);
  localparam int unsigned AW = (SHELL_COUNT > 1) ? $clog2(SHELL_COUNT) : 1;
  localparam int unsigned FW = $clog2(SHELL_COUNT + 1);
  localparam int unsigned PW = COEF_BITS + fsw_pkg::WGT_W;
  localparam int unsigned RT = fsw_pkg::RT_STEPS;
  localparam int unsigned XW = 20;
  localparam int unsigned RW = 21;

  logic                     en;
  logic                     pop_vox, pop_load, pipe_empty, idx_ok, val_fail;
  logic [FW-1:0]            ffs_r;
  logic [17:0]              r2;

  logic [RT:0]              rt_v_r;
  logic [XW-1:0]            rt_x_r   [RT+1];
  logic [RW-1:0]            rt_res_r [RT+1];
  logic [COEF_BITS-1:0]     rt_re_r  [RT+1];
  logic [COEF_BITS-1:0]     rt_im_r  [RT+1];
  logic [RW-1:0]            rt_one   [RT];
  logic [RW-1:0]            rt_sum   [RT];
  logic [XW-1:0]            rt_x_nxt [RT];
  logic [RW-1:0]            rt_res_nxt [RT];

  logic [9:0]               t_root, fl, s_rnd, ceil_r2, half, shell;
  logic [10:0]              t_inc;
  logic                     pass, shell_ok;

  logic [fsw_pkg::WGT_W-1:0] wmem [SHELL_COUNT];
  logic [fsw_pkg::WGT_W-1:0] rdata_r;
  logic                      rd_v_r, rd_ok_r;
  logic [COEF_BITS-1:0]      rd_re_r, rd_im_r;

  logic [fsw_pkg::WGT_W-1:0] w_sel;
  logic                      neg_re, neg_im;
  logic [COEF_BITS-1:0]      mag_re, mag_im;
  logic                      mu_v_r, mu_neg_re_r, mu_neg_im_r;
  logic [PW-1:0]             mu_prod_re_r, mu_prod_im_r;
  logic [fsw_pkg::WGT_W-1:0] mu_w_r;

  logic [PW:0]               rnd_re, rnd_im;
  logic [COEF_BITS-1:0]      q_mag_re, q_mag_im;
  logic                      out_valid_r;
  logic [COEF_BITS-1:0]      out_re_r, out_im_r;
  logic [fsw_pkg::OUTW_W-1:0] out_w_r;

  // the whole pipeline moves together; the output register parts it from the sink
  assign en = !out_valid_r || out_ready;

  assign pipe_empty = !(|rt_v_r) && !rd_v_r;
  assign pop_vox  = q_valid && (q_item.action == fsw_pkg::ACT_VOXEL) && en && !wu_busy;
  assign pop_load = q_valid && (q_item.action == fsw_pkg::ACT_LOAD) && !wu_busy && pipe_empty;
  assign q_pop    = pop_vox || pop_load;
  assign idx_ok   = 32'(q_item.shell_index) < SHELL_COUNT;
  assign val_fail = q_item.shell_value < fsc_threshold;

  assign wu_req.start = pop_load && idx_ok;
  assign wu_req.idx   = q_item.shell_index;
  assign wu_req.value = q_item.shell_value;

  // failed shell mark only ever falls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ffs_r <= FW'(SHELL_COUNT);
    end else if (pop_load && idx_ok && val_fail &&
                 (32'(q_item.shell_index) < 32'(ffs_r))) begin
      ffs_r <= FW'(q_item.shell_index);
    end
  end

  assign r2 = 18'(q_item.sq_x) + 18'(q_item.sq_y) + 18'(q_item.sq_z);

  // one root digit per stage on 4*r2
  always_comb begin
    for (int k = 0; k < RT; k++) begin
      rt_one[k] = RW'(1) << (2 * (RT - 1 - k));
      rt_sum[k] = rt_res_r[k] + rt_one[k];
      if ({1'b0, rt_x_r[k]} >= rt_sum[k]) begin
        rt_x_nxt[k]   = XW'({1'b0, rt_x_r[k]} - rt_sum[k]);
        rt_res_nxt[k] = (rt_res_r[k] >> 1) + rt_one[k];
      end else begin
        rt_x_nxt[k]   = rt_x_r[k];
        rt_res_nxt[k] = rt_res_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_v_r <= '0;
    end else if (en) begin
      rt_v_r <= {rt_v_r[RT-1:0], pop_vox};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_x_r[0]   <= {r2, 2'b00};
      rt_res_r[0] <= '0;
      rt_re_r[0]  <= q_re;
      rt_im_r[0]  <= q_im;
      for (int k = 0; k < RT; k++) begin
        rt_x_r[k+1]   <= rt_x_nxt[k];
        rt_res_r[k+1] <= rt_res_nxt[k];
        rt_re_r[k+1]  <= rt_re_r[k];
        rt_im_r[k+1]  <= rt_im_r[k];
      end
    end
  end

  // floor(2*sqrt(r2)) gives the floor, the rounded and the ceiling radius
  always_comb begin
    t_root  = rt_res_r[RT][9:0];
    t_inc   = {1'b0, t_root} + 11'd1;
    fl      = {1'b0, t_root[9:1]};
    s_rnd   = t_inc[10:1];
    ceil_r2 = fl + {9'd0, (rt_x_r[RT] != '0)};
    half    = {2'b00, volume_size[8:1]};
    if (filter_mode == fsw_pkg::MODE_BINARY) begin
      pass  = ceil_r2 < half;
      shell = fl;
    end else begin
      pass  = (s_rnd + 10'd1) < half;
      shell = s_rnd;
    end
    shell_ok = pass && (32'(shell) < SHELL_COUNT) && (32'(shell) < 32'(ffs_r));
  end

  always_ff @(posedge clk) begin
    if (wu_wr.we) begin
      wmem[AW'(wu_wr.idx)] <= wu_wr.weight;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= wmem[shell[AW-1:0]];
      rd_ok_r <= shell_ok;
      rd_re_r <= rt_re_r[RT];
      rd_im_r <= rt_im_r[RT];
    end
  end

  always_comb begin
    if (filter_mode == fsw_pkg::MODE_BINARY) begin
      w_sel = (rd_ok_r && (rdata_r != '0)) ? fsw_pkg::WEIGHT_ONE : '0;
    end else begin
      w_sel = rd_ok_r ? rdata_r : '0;
    end
    neg_re = rd_re_r[COEF_BITS-1];
    neg_im = rd_im_r[COEF_BITS-1];
    mag_re = neg_re ? (~rd_re_r + 1'b1) : rd_re_r;
    mag_im = neg_im ? (~rd_im_r + 1'b1) : rd_im_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mu_prod_re_r <= PW'(mag_re) * PW'(w_sel);
      mu_prod_im_r <= PW'(mag_im) * PW'(w_sel);
      mu_neg_re_r  <= neg_re;
      mu_neg_im_r  <= neg_im;
      mu_w_r       <= w_sel;
    end
  end

  // round half away from zero on the magnitude, then restore the sign
  always_comb begin
    rnd_re   = {1'b0, mu_prod_re_r} + (PW+1)'(16384);
    rnd_im   = {1'b0, mu_prod_im_r} + (PW+1)'(16384);
    q_mag_re = rnd_re[15 +: COEF_BITS];
    q_mag_im = rnd_im[15 +: COEF_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      mu_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      rd_v_r      <= rt_v_r[RT];
      mu_v_r      <= rd_v_r;
      out_valid_r <= mu_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_re_r <= mu_neg_re_r ? (~q_mag_re + 1'b1) : q_mag_re;
      out_im_r <= mu_neg_im_r ? (~q_mag_im + 1'b1) : q_mag_im;
      out_w_r  <= mu_w_r[fsw_pkg::OUTW_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_re     = out_re_r;
  assign out_im     = out_im_r;
  assign out_weight = out_w_r;

  `FSW_ASSERT_IMPL(a_load_after_drain, pop_load, !(|rt_v_r) && !rd_v_r, "load taken with voxels in flight")
  `FSW_ASSERT_IMPL(a_no_voxel_while_busy, wu_busy, !pop_vox, "voxel taken during weight update")
  `FSW_ASSERT_IMPL(a_write_clear_of_reads, wu_wr.we, !(|rt_v_r), "weight written while a voxel may read it")
  `FSW_ASSERT_NEXT(a_fail_mark_sticky, 1'b1, ffs_r <= $past(ffs_r), "failed shell mark rose")
endmodule
`default_nettype wire

@@ rtl/fsc_shell_weight_filter.sv @@
// top level of the resolution shell weighting filter
`default_nettype none
// Weights Fourier coefficients by resolution shell. A load transaction
// (action 0) stores the Q1.15 weight round(32768*sqrt(2f/(f+1))) of one shell
// and lowers the failed-shell mark when f is below fsc_threshold; it gives no
// result. A voxel transaction (action 1) gives one result: the coefficient
// scaled by the weight of the shell its radius from the centre falls in, in
// final or binary mode. Voxels stream at one per cycle while the result
// channel is ready and no weight update runs; they pass through the ten-stage
// radius root pipeline, the weight store read and the multiplier stage. A load
// waits until earlier voxels have read the weight store, then holds the back
// end while the serial divide (33 steps) and square root (17 steps) unit works.
// Every shell a voxel reads must have been loaded since reset. Configuration
// writes are accepted in any cycle but are meant only while the block is idle.
module fsc_shell_weight_filter #(
  parameter int unsigned COEF_BITS   = 32,
  parameter int unsigned SHELL_COUNT = 128
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // item channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_action,
  input  wire logic [fsw_pkg::IDX_W-1:0]           in_shell_index,
  input  wire logic signed [fsw_pkg::VAL_W-1:0]    in_shell_value,
  input  wire logic [fsw_pkg::CRD_W-1:0]           in_coord_x,
  input  wire logic [fsw_pkg::CRD_W-1:0]           in_coord_y,
  input  wire logic [fsw_pkg::CRD_W-1:0]           in_coord_z,
  input  wire logic signed [COEF_BITS-1:0]         in_coef_re,
  input  wire logic signed [COEF_BITS-1:0]         in_coef_im,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [COEF_BITS-1:0]              out_re,
  output logic signed [COEF_BITS-1:0]              out_im,
  output logic [fsw_pkg::OUTW_W-1:0]               out_applied_weight,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [fsw_pkg::CFGI_W-1:0]          cfg_index,
  input  wire logic [fsw_pkg::VAL_W-1:0]           cfg_data
);
  localparam int unsigned Q_W = $bits(fsw_pkg::q_item_t) + 2 * COEF_BITS;

  logic                               filter_mode_r;
  logic [fsw_pkg::VOL_W-1:0]          volume_size_r;
  logic signed [fsw_pkg::VAL_W-1:0]   fsc_threshold_r;

  logic                  f_valid, f_ready;
  fsw_pkg::q_item_t      f_item;
  logic [COEF_BITS-1:0]  f_re, f_im;
  logic                  q_valid, q_pop;
  logic [Q_W-1:0]        q_data;
  fsw_pkg::q_item_t      q_item;
  logic [COEF_BITS-1:0]  q_re, q_im;
  logic                  wu_busy;
  fsw_pkg::wu_req_t      wu_req;
  fsw_pkg::wu_wr_t       wu_wr;

  // configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_mode_r   <= fsw_pkg::MODE_FINAL;
      volume_size_r   <= fsw_pkg::VOLUME_SIZE_RST;
      fsc_threshold_r <= fsw_pkg::THRESHOLD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        fsw_pkg::CFG_FILTER_MODE:   filter_mode_r   <= cfg_data[0];
        fsw_pkg::CFG_VOLUME_SIZE:   volume_size_r   <= cfg_data[fsw_pkg::VOL_W-1:0];
        fsw_pkg::CFG_FSC_THRESHOLD: fsc_threshold_r <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // front: takes the transaction and squares the centre offsets
  fsw_front #(
    .COEF_BITS (COEF_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_shell_index (in_shell_index),
    .in_shell_value (in_shell_value),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_coef_re     (in_coef_re),
    .in_coef_im     (in_coef_im),
    .volume_size    (volume_size_r),
    .f_valid        (f_valid),
    .f_ready        (f_ready),
    .f_item         (f_item),
    .f_re           (f_re),
    .f_im           (f_im)
  );

  // decoupling queue, so a stalled back end does not stop the front at once
  fsw_queue #(
    .DATA_W (Q_W),
    .DEPTH  (4)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_item, f_re, f_im}),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_data)
  );

  assign q_item = q_data[Q_W-1 -: $bits(fsw_pkg::q_item_t)];
  assign q_re   = q_data[2*COEF_BITS-1 -: COEF_BITS];
  assign q_im   = q_data[COEF_BITS-1:0];

  // back: radius, shell lookup and scaling
  fsw_back #(
    .COEF_BITS   (COEF_BITS),
    .SHELL_COUNT (SHELL_COUNT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_item        (q_item),
    .q_re          (q_re),
    .q_im          (q_im),
    .filter_mode   (filter_mode_r),
    .volume_size   (volume_size_r),
    .fsc_threshold (fsc_threshold_r),
    .wu_busy       (wu_busy),
    .wu_req        (wu_req),
    .wu_wr         (wu_wr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_re        (out_re),
    .out_im        (out_im),
    .out_weight    (out_applied_weight)
  );

  // serial weight calculation for load transactions
  fsw_wunit u_wunit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (wu_req),
    .busy  (wu_busy),
    .wr    (wu_wr)
  );
endmodule
`default_nettype wire
